// File: rtl/dra_pkg.sv
// ----------------------------------------------------------------------------
// dra_pkg - DMA request route allocator shared definitions
// Codes, sizes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dra_pkg;

  localparam int MAX_ROUTES    = 64;
  localparam int ROUTE_W       = 6;   // route index width
  localparam int CNT_W         = 7;   // route count width (holds MAX_ROUTES)
  localparam int SRC_W         = 5;   // stored source width
  localparam int SOURCE_INPUTS = 32;
  localparam int CHANNEL_TYPES = 2;

  // actions
  localparam logic [1:0] ACT_ALLOC  = 2'd0;
  localparam logic [1:0] ACT_FREE   = 2'd1;
  localparam logic [1:0] ACT_RESUME = 2'd2;

  // route states
  localparam logic [1:0] ST_FREE   = 2'd0;
  localparam logic [1:0] ST_USED   = 2'd1;
  localparam logic [1:0] ST_TOFREE = 2'd2;

  // result status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_BAD_TYPE  = 3'd1;
  localparam logic [2:0] STAT_BAD_SRC   = 3'd2;
  localparam logic [2:0] STAT_BUSY      = 3'd3;
  localparam logic [2:0] STAT_BAD_ROUTE = 3'd4;

  typedef struct packed {
    logic       load;        // latch the accepted beat, set scan start
    logic       issue;       // read the route table at the scan address
    logic       claim;       // take the route just read, result ok
    logic       emit_status; // single result carrying code, last set, rest zero
    logic [2:0] code;
    logic       free_rt;     // free route_index straight from the ports
    logic       bank;        // resume: hold route just read as next result
    logic       flush;       // resume: final result
  } dra_cmd_t;

  typedef struct packed {
    logic       type_bad;
    logic       src_bad;
    logic       ridx_bad;
    logic       addr_lt_n;
    logic       rd_pend;
    logic [1:0] rd_state;
  } dra_sts_t;

  function automatic logic [ROUTE_W-1:0] mux_value(input logic [SRC_W-1:0] src);
    mux_value = {src, 1'b1};
  endfunction

endpackage

// File: rtl/dma_request_route_allocator.sv
// ----------------------------------------------------------------------------
// dma_request_route_allocator - DMA request route table
// Allocates, frees and reprograms peripheral request routes.
// ----------------------------------------------------------------------------
// Usage: drive action and its operands with start; a beat is taken on a clock
// edge where start is high and busy is low. Results appear one per cycle on
// the result ports, flagged by result_valid for exactly one cycle; last marks
// the final result of a beat. There is no back-pressure on results.
// route_count is loaded through cfg_we/cfg_wdata; the user must load it only
// while the block is idle, as the block itself does not enforce this.
// Timing: a bad-operand allocate or a free beat gives its result the cycle
// after it is taken and busy stays low; an unused action code gives none.
// Allocate reads one route table entry a cycle over every second route; the
// result lands in the first cycle busy is low. Resume reads every route once;
// each result goes out when the next route to rewrite is found, the final
// one in the first cycle busy is low. The route table has a single read
// port; one beat is in hand at a time.
// Reset: all routes read as free, route_count returns to 64, nothing pending.
// ----------------------------------------------------------------------------
module dma_request_route_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action,
  input  logic [1:0]                   channel_type,
  input  logic [5:0]                   req_source,
  input  logic [dra_pkg::ROUTE_W-1:0]  route_index,
  input  logic                         powered,
  input  logic                         cfg_we,
  input  logic [dra_pkg::CNT_W-1:0]    cfg_wdata,
  output logic                         result_valid,
  output logic [2:0]                   status,
  output logic [dra_pkg::ROUTE_W-1:0]  granted_route,
  output logic                         write_valid,
  output logic [dra_pkg::ROUTE_W-1:0]  write_channel,
  output logic [dra_pkg::ROUTE_W-1:0]  write_value,
  output logic                         last
);
  import dra_pkg::*;

  dra_cmd_t cmd;
  dra_sts_t sts;

  dra_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  dra_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .action            (action),
    .channel_type      (channel_type),
    .req_source        (req_source),
    .route_index       (route_index),
    .powered           (powered),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .sts               (sts),
    .result_valid      (result_valid),
    .status            (status),
    .granted_route     (granted_route),
    .write_valid       (write_valid),
    .write_channel     (write_channel),
    .write_value       (write_value),
    .last              (last)
  );

endmodule

// File: rtl/dra_ctrl.sv
// ----------------------------------------------------------------------------
// dra_ctrl - allocator sequencer
// Decodes each accepted beat and steps the route table scans.
// ----------------------------------------------------------------------------
module dra_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        action,
  input  dra_pkg::dra_sts_t sts,
  output dra_pkg::dra_cmd_t cmd,
  output logic              busy
);
  import dra_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ALLOC  = 2'd1;
  localparam logic [1:0] S_RESUME = 2'd2;

  logic [1:0] state, state_next;
  logic       hit;

  assign busy = (state != S_IDLE);
  assign hit  = sts.rd_pend && (sts.rd_state != ST_USED);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = STAT_OK;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (action)
            ACT_ALLOC: begin
              if (sts.type_bad) begin
                cmd.emit_status = 1'b1;
                cmd.code        = STAT_BAD_TYPE;
              end else if (sts.src_bad) begin
                cmd.emit_status = 1'b1;
                cmd.code        = STAT_BAD_SRC;
              end else begin
                state_next = S_ALLOC;
              end
            end
            ACT_FREE: begin
              if (sts.ridx_bad) begin
                cmd.emit_status = 1'b1;
                cmd.code        = STAT_BAD_ROUTE;
              end else begin
                cmd.free_rt = 1'b1;
              end
            end
            ACT_RESUME: state_next = S_RESUME;
            default: ;
          endcase
        end
      end
      S_ALLOC: begin
        if (hit) begin
          cmd.claim  = 1'b1;
          state_next = S_IDLE;
        end else if (sts.addr_lt_n) begin
          cmd.issue = 1'b1;
        end else begin
          // scan exhausted with no free route found
          cmd.emit_status = 1'b1;
          cmd.code        = STAT_BUSY;
          state_next      = S_IDLE;
        end
      end
      S_RESUME: begin
        if (sts.rd_pend && (sts.rd_state == ST_USED || sts.rd_state == ST_TOFREE)) begin
          cmd.bank = 1'b1;
        end
        if (sts.addr_lt_n) begin
          cmd.issue = 1'b1;
        end else if (!sts.rd_pend) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_claim_needs_read: assert property (@(posedge clk) disable iff (rst)
    cmd.claim |-> sts.rd_pend)
    else $error("claim without a table read in flight");
  a_free_only_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.free_rt || cmd.load) |-> (state == S_IDLE))
    else $error("beat taken outside idle");
`endif

endmodule

// File: rtl/dra_datapath.sv
// ----------------------------------------------------------------------------
// dra_datapath - route table and result register
// Route state and source memories, scan address, resume hold and result beat.
// ----------------------------------------------------------------------------
module dra_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [1:0]                   action,
  input  logic [1:0]                   channel_type,
  input  logic [5:0]                   req_source,
  input  logic [dra_pkg::ROUTE_W-1:0]  route_index,
  input  logic                         powered,
  input  logic                         cfg_we,
  input  logic [dra_pkg::CNT_W-1:0]    cfg_wdata,
  input  dra_pkg::dra_cmd_t            cmd,
  output dra_pkg::dra_sts_t            sts,
  output logic                         result_valid,
  output logic [2:0]                   status,
  output logic [dra_pkg::ROUTE_W-1:0]  granted_route,
  output logic                         write_valid,
  output logic [dra_pkg::ROUTE_W-1:0]  write_channel,
  output logic [dra_pkg::ROUTE_W-1:0]  write_value,
  output logic                         last
);
  import dra_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_ROUTES);
  localparam logic [5:0]       SRC_LIM  = 6'(SOURCE_INPUTS);
  localparam logic [1:0]       TYPE_LIM = 2'(CHANNEL_TYPES);
  localparam logic [CNT_W-1:0] STEP     = CNT_W'(CHANNEL_TYPES);

  logic [CNT_W-1:0]   route_count;
  logic [CNT_W-1:0]   n_eff;

  logic [1:0]         st_mem  [MAX_ROUTES];
  logic [SRC_W-1:0]   src_mem [MAX_ROUTES];
  logic [MAX_ROUTES-1:0] vld;

  logic [CNT_W-1:0]   addr;
  logic               alloc_mode;
  logic [SRC_W-1:0]   src_q;
  logic               pwr_q;

  logic               rd_pend;
  logic [ROUTE_W-1:0] rd_idx;
  logic [1:0]         st_rd;
  logic [SRC_W-1:0]   src_rd;
  logic               rd_vld;
  logic [1:0]         rd_state;

  logic               have_pend;
  logic [ROUTE_W-1:0] pend_ch;
  logic [ROUTE_W-1:0] pend_val;

  logic               st_we;
  logic [ROUTE_W-1:0] st_wa;
  logic [1:0]         st_wd;

  logic               res_valid_next;
  logic [2:0]         res_status_next;
  logic [ROUTE_W-1:0] res_granted_next;
  logic               res_wv_next;
  logic [ROUTE_W-1:0] res_wch_next;
  logic [ROUTE_W-1:0] res_wval_next;
  logic               res_last_next;

  assign n_eff    = (route_count > MAX_CNT) ? MAX_CNT : route_count;
  assign rd_state = rd_vld ? st_rd : ST_FREE;

  assign sts.type_bad  = (channel_type >= TYPE_LIM);
  assign sts.src_bad   = (req_source >= SRC_LIM);
  assign sts.ridx_bad  = ({1'b0, route_index} >= n_eff);
  assign sts.addr_lt_n = (addr < n_eff);
  assign sts.rd_pend   = rd_pend;
  assign sts.rd_state  = rd_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      route_count <= MAX_CNT;
    end else if (cfg_we) begin
      route_count <= cfg_wdata;
    end
  end

  // beat capture and scan address
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      alloc_mode <= (action == ACT_ALLOC);
      src_q      <= req_source[SRC_W-1:0];
      pwr_q      <= powered;
      addr       <= (action == ACT_ALLOC) ? CNT_W'(channel_type) : '0;
    end else if (cmd.issue) begin
      addr <= addr + (alloc_mode ? STEP : CNT_W'(1));
    end
  end

  // table write port
  always_comb begin
    st_we = cmd.claim || cmd.free_rt || (cmd.bank && rd_state == ST_TOFREE);
    st_wa = cmd.free_rt ? route_index : rd_idx;
    if (cmd.claim) begin
      st_wd = ST_USED;
    end else if (cmd.free_rt) begin
      st_wd = powered ? ST_FREE : ST_TOFREE;
    end else begin
      st_wd = ST_FREE;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_wa] <= st_wd;
    end
    if (cmd.claim) begin
      src_mem[rd_idx] <= src_q;
    end
    if (cmd.issue) begin
      st_rd  <= st_mem[addr[ROUTE_W-1:0]];
      src_rd <= src_mem[addr[ROUTE_W-1:0]];
      rd_vld <= vld[addr[ROUTE_W-1:0]];
      rd_idx <= addr[ROUTE_W-1:0];
    end
  end

  // entries never written read as free
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (st_we) begin
      vld[st_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.issue;
    end
  end

  // resume holds one result back so the final one can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      have_pend <= 1'b0;
    end else if (cmd.load || cmd.flush) begin
      have_pend <= 1'b0;
    end else if (cmd.bank) begin
      have_pend <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bank) begin
      pend_ch  <= rd_idx;
      pend_val <= (rd_state == ST_USED) ? mux_value(src_rd) : '0;
    end
  end

  always_comb begin
    res_valid_next   = 1'b0;
    res_status_next  = STAT_OK;
    res_granted_next = '0;
    res_wv_next      = 1'b0;
    res_wch_next     = '0;
    res_wval_next    = '0;
    res_last_next    = 1'b1;
    if (cmd.emit_status) begin
      res_valid_next  = 1'b1;
      res_status_next = cmd.code;
    end else if (cmd.claim) begin
      res_valid_next   = 1'b1;
      res_granted_next = rd_idx;
      res_wv_next      = pwr_q;
      res_wch_next     = pwr_q ? rd_idx : '0;
      res_wval_next    = pwr_q ? mux_value(src_q) : '0;
    end else if (cmd.free_rt) begin
      res_valid_next = 1'b1;
      res_wv_next    = powered;
      res_wch_next   = powered ? route_index : '0;
    end else if (cmd.bank && have_pend) begin
      res_valid_next = 1'b1;
      res_wv_next    = 1'b1;
      res_wch_next   = pend_ch;
      res_wval_next  = pend_val;
      res_last_next  = 1'b0;
    end else if (cmd.flush) begin
      res_valid_next = 1'b1;
      res_wv_next    = have_pend;
      res_wch_next   = have_pend ? pend_ch : '0;
      res_wval_next  = have_pend ? pend_val : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    status        <= res_status_next;
    granted_route <= res_granted_next;
    write_valid   <= res_wv_next;
    write_channel <= res_wch_next;
    write_value   <= res_wval_next;
    last          <= res_last_next;
  end

`ifndef NO_ASSERTIONS
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.claim, cmd.free_rt, cmd.bank, cmd.emit_status, cmd.flush}))
    else $error("conflicting table or result commands");
  a_issue_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (addr < n_eff))
    else $error("table read beyond route count");
`endif

endmodule
